### src/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg: shared types and constants of the k-means clustering block
// Word formats, cell link records, opcodes and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package kmc_pkg;

  localparam int COORD_W = 16;  // Q7.8 coordinate
  localparam int CL_W    = 3;   // cluster index, up to eight clusters
  localparam int DIM_W   = 3;   // coordinate index, up to eight dimensions
  localparam int PT_W    = 16;  // point index, up to 65536 points
  localparam int DIST_W  = 35;  // squared distance over eight dimensions
  localparam int CFG_IW  = 3;   // configuration register index

  typedef enum logic [CFG_IW-1:0] {
    CFG_POINT_COUNT   = 3'd0,
    CFG_DIM_COUNT     = 3'd1,
    CFG_CLUSTER_COUNT = 3'd2,
    CFG_MAX_ITER      = 3'd3,
    CFG_MIN_IMPROVE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_ASSIGN,
    OP_ACCUM
  } op_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEED,
    ST_ASSIGN,
    ST_CHECK,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIVIDE,
    ST_EMIT
  } st_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_LOAD,
    DV_STEP,
    DV_STORE
  } dv_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_value;
    logic                      last_coord;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_value;
    logic                      last_center;
  } out_word_t;

  // coordinate travelling along the cell row
  typedef struct packed {
    logic                      vld;
    op_t                       op;
    logic                      first;
    logic                      last;
    logic [DIM_W-1:0]          dim;
    logic [CL_W-1:0]           tag;
    logic [PT_W-1:0]           pt;
    logic signed [COORD_W-1:0] coord;
  } elem_t;

  // running nearest-centre decision of one point
  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] dmin;
    logic [CL_W-1:0]   idx;
    logic [DIST_W-1:0] err;
    logic [PT_W-1:0]   pt;
  } bst_t;

endpackage

`default_nettype wire

### src/kmc_cell.sv
// ----------------------------------------------------------------------------
// kmc_cell: one centre of the clustering row
// Holds one centre, its member sums and count; measures squared distance,
// folds the nearest-centre decision and divides sums into the new centre.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_cell
  import kmc_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int MAX_POINTS = 1024,
  parameter int MAX_DIMS   = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire elem_t                     elem_i,
  output elem_t                          elem_o,
  input  wire bst_t                      bst_i,
  output bst_t                           bst_o,
  input  wire logic [CL_W:0]             k_i,
  input  wire logic [3:0]                d_i,
  input  wire logic                      clr_i,
  input  wire logic                      div_go_i,
  output logic                           div_busy_o,
  input  wire logic [DIM_W-1:0]          rd_dim_i,
  output logic signed [COORD_W-1:0]      center_o
);

  localparam int SW  = COORD_W + $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int LDW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int STW = $clog2(SW);

  elem_t                     s1_r;
  logic [31:0]               prod_r;
  logic [DIST_W-1:0]         acc_r;
  bst_t                      bst_r;
  logic signed [COORD_W-1:0] cen_r [MAX_DIMS];
  logic signed [SW-1:0]      sum_r [MAX_DIMS];
  logic [CW-1:0]             cnt_r;

  dv_state_t                 dv_state_r, dv_state_nxt;
  logic [DIM_W-1:0]          dv_dim_r;
  logic [STW-1:0]            dv_step_r;
  logic [SW-1:0]             dq_r;
  logic [CW-1:0]             rem_r;
  logic                      neg_r;

  logic signed [16:0]        diff;
  logic signed [33:0]        sq;
  logic [DIST_W-1:0]         total;
  logic                      take;
  logic                      active;
  logic                      mine;
  bst_t                      bst_nxt;
  logic [CW:0]               trial;
  logic                      ge;
  logic signed [SW-1:0]      sv;
  logic [COORD_W-1:0]        qv;
  logic                      dv_last;

  // distance term of the incoming coordinate
  always_comb begin
    diff = 17'(elem_i.coord) - 17'(cen_r[elem_i.dim[LDW-1:0]]);
    sq   = 34'(diff) * 34'(diff);
  end

  always_comb begin
    total  = s1_r.first ? DIST_W'(prod_r) : acc_r + DIST_W'(prod_r);
    active = 32'(IDX) < 32'(k_i);
    take   = (IDX == 0) || (total <= bst_i.dmin);
    mine   = s1_r.tag == CL_W'(IDX);
    bst_nxt.vld  = s1_r.vld && s1_r.last && (s1_r.op == OP_ASSIGN);
    bst_nxt.dmin = (active && take) ? total : bst_i.dmin;
    bst_nxt.idx  = (active && take) ? CL_W'(IDX) : bst_i.idx;
    bst_nxt.err  = mine ? total : bst_i.err;
    bst_nxt.pt   = s1_r.pt;
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    trial   = {rem_r, dq_r[SW-1]};
    ge      = trial >= {1'b0, cnt_r};
    sv      = sum_r[dv_dim_r[LDW-1:0]];
    qv      = neg_r ? COORD_W'(-dq_r[COORD_W-1:0]) : dq_r[COORD_W-1:0];
    dv_last = (4'(dv_dim_r) + 4'd1) == d_i;
  end

  always_comb begin
    dv_state_nxt = dv_state_r;
    case (dv_state_r)
      DV_IDLE:  if (div_go_i) dv_state_nxt = DV_LOAD;
      DV_LOAD:  dv_state_nxt = DV_STEP;
      DV_STEP:  if (dv_step_r == STW'(SW - 1)) dv_state_nxt = DV_STORE;
      DV_STORE: dv_state_nxt = dv_last ? DV_IDLE : DV_LOAD;
      default:  dv_state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld   <= 1'b0;
      bst_r.vld  <= 1'b0;
      dv_state_r <= DV_IDLE;
    end else begin
      s1_r       <= elem_i;
      bst_r      <= bst_nxt;
      dv_state_r <= dv_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sq[31:0];
    if (s1_r.vld) begin
      acc_r <= total;
    end

    if (clr_i) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        sum_r[i] <= '0;
      end
      cnt_r <= '0;
    end else if (s1_r.vld && (s1_r.op == OP_ACCUM) && mine) begin
      sum_r[s1_r.dim[LDW-1:0]] <= sum_r[s1_r.dim[LDW-1:0]] + SW'(s1_r.coord);
      if (s1_r.last) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end

    if (s1_r.vld && (s1_r.op == OP_SEED) && mine) begin
      cen_r[s1_r.dim[LDW-1:0]] <= s1_r.coord;
    end

    case (dv_state_r)
      DV_IDLE: begin
        dv_dim_r <= '0;
      end
      DV_LOAD: begin
        neg_r     <= sv[SW-1];
        dq_r      <= sv[SW-1] ? SW'(-sv) : SW'(sv);
        rem_r     <= '0;
        dv_step_r <= '0;
      end
      DV_STEP: begin
        rem_r     <= ge ? CW'(trial - {1'b0, cnt_r}) : trial[CW-1:0];
        dq_r      <= {dq_r[SW-2:0], ge};
        dv_step_r <= dv_step_r + 1'b1;
      end
      DV_STORE: begin
        cen_r[dv_dim_r[LDW-1:0]] <= (cnt_r == '0) ? '0 : $signed(qv);
        dv_dim_r <= dv_dim_r + 1'b1;
      end
      default: begin
        dv_dim_r <= '0;
      end
    endcase
  end

  assign elem_o     = s1_r;
  assign bst_o      = bst_r;
  assign div_busy_o = dv_state_r != DV_IDLE;
  assign center_o   = cen_r[rd_dim_i[LDW-1:0]];

endmodule

`default_nettype wire

### src/kmeans_lloyd_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering: Lloyd k-means over a loaded Q7.8 data set
// Load: one coordinate word per cycle; the word with last_coord starts a run.
// Run: a seed pass; per round an assignment pass, a check state (which may end the
//   run) and an accumulation pass, each pass one coordinate a cycle plus a row drain,
//   then the serial dividers of the cells, SW=16+log2 N.
// Emit: k*d centre words, one per cycle while out_ready holds high.
// Reset (synchronous, rst_n low) returns to loading with the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module kmeans_lloyd_clustering
  import kmc_pkg::*;
#(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_DIMS     = 8,
  parameter int MAX_CLUSTERS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_word_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [39:0]       cfg_data
);

  localparam int DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int EW    = DIST_W + PW;
  localparam int CMPW  = ((EW > 40) ? EW : 40) + 1;
  localparam int DRAIN = MAX_CLUSTERS + 4;
  localparam int DRW   = $clog2(DRAIN + 1);
  localparam int CLIW  = $clog2(MAX_CLUSTERS);

  // configuration registers
  logic [10:0]         pc_r;
  logic [3:0]          dc_r;
  logic [3:0]          cc_r;
  logic [7:0]          mi_r;
  logic [39:0]         mimp_r;

  // clamped sizes, frozen at the start of a run
  logic [NW-1:0]       n_c;
  logic [3:0]          d_c;
  logic [3:0]          k_c;
  logic [3:0]          d_r;
  logic [3:0]          k_r;
  logic [TW-1:0]       nd_r;
  logic [TW-1:0]       kd_r;

  st_t                 state_r, state_nxt;
  logic [TW-1:0]       pos_r;
  logic [TW-1:0]       iss_r;
  logic [DIM_W-1:0]    dim_r;
  logic [PW-1:0]       pt_r;
  logic [DRW-1:0]      dr_r;
  logic [7:0]          rounds_r;
  logic [EW-1:0]       sse_r;
  logic [EW-1:0]       prev_r;

  logic signed [COORD_W-1:0] point_mem [DEPTH];
  logic [CL_W-1:0]           member_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] pm_q_r;
  logic [CL_W-1:0]           mm_q_r;
  elem_t                     c1_r;

  logic [CLIW-1:0]     em_cl_r;
  logic [DIM_W-1:0]    em_dim_r;
  logic                em_done_r;
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic                in_acc;
  logic                out_acc;
  logic [TW-1:0]       total_c;
  logic                issuing;
  logic                last_dim;
  logic                pass_done;
  logic                stop_c;
  logic                em_load;
  logic                em_last;
  logic                clr;
  logic                div_go;
  logic                any_busy;
  op_t                 pass_op;
  elem_t               elem0;

  elem_t                     elem_w [MAX_CLUSTERS+1];
  bst_t                      bst_w  [MAX_CLUSTERS+1];
  logic [MAX_CLUSTERS-1:0]   busy_w;
  logic signed [COORD_W-1:0] cen_w  [MAX_CLUSTERS];

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign any_busy  = |busy_w;

  // ---- configuration: take a word at any time, drop unknown indexes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= 11'd1024;
      dc_r   <= 4'd1;
      cc_r   <= 4'd2;
      mi_r   <= 8'd50;
      mimp_r <= 40'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POINT_COUNT:   pc_r   <= cfg_data[10:0];
        CFG_DIM_COUNT:     dc_r   <= cfg_data[3:0];
        CFG_CLUSTER_COUNT: cc_r   <= cfg_data[3:0];
        CFG_MAX_ITER:      mi_r   <= cfg_data[7:0];
        CFG_MIN_IMPROVE:   mimp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate sizes into the legal ranges; clusters never outnumber points
  always_comb begin
    if (pc_r == '0) begin
      n_c = NW'(1);
    end else if (32'(pc_r) > 32'(MAX_POINTS)) begin
      n_c = NW'(MAX_POINTS);
    end else begin
      n_c = NW'(pc_r);
    end
    if (dc_r == '0) begin
      d_c = 4'd1;
    end else if (32'(dc_r) > 32'(MAX_DIMS)) begin
      d_c = 4'(MAX_DIMS);
    end else begin
      d_c = dc_r;
    end
    if (cc_r == '0) begin
      k_c = 4'd1;
    end else if (32'(cc_r) > 32'(MAX_CLUSTERS)) begin
      k_c = 4'(MAX_CLUSTERS);
    end else begin
      k_c = cc_r;
    end
    if (32'(k_c) > 32'(n_c)) begin
      k_c = 4'(n_c);
    end
  end

  // ---- pass sequencing ----
  assign total_c   = (state_r == ST_SEED) ? kd_r : nd_r;
  assign last_dim  = (4'(dim_r) + 4'd1) == d_r;
  assign pass_done = (iss_r == total_c) && (dr_r == DRW'(DRAIN));
  // stop once the error drop (possibly negative) is within the threshold
  assign stop_c    = CMPW'(prev_r) <= (CMPW'(sse_r) + CMPW'(mimp_r));
  assign em_last   = ((4'(em_cl_r) + 4'd1) == k_r) && ((4'(em_dim_r) + 4'd1) == d_r);
  assign em_load   = (state_r == ST_EMIT) && !em_done_r && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:   if (in_acc && in_data.last_coord) state_nxt = ST_SEED;
      ST_SEED:   if (pass_done) state_nxt = (mi_r == '0) ? ST_EMIT : ST_ASSIGN;
      ST_ASSIGN: if (pass_done) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = ((rounds_r >= 8'd2) && stop_c) ? ST_EMIT : ST_ACCUM;
      ST_ACCUM:  if (pass_done) state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (!any_busy) begin
          state_nxt = ((9'(rounds_r) + 9'd1) == 9'(mi_r)) ? ST_EMIT : ST_ASSIGN;
        end
      end
      ST_EMIT:   if (out_acc && out_data_r.last_center) state_nxt = ST_LOAD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = state_r == ST_LOAD;
    clr      = state_r == ST_CHECK;
    div_go   = state_r == ST_DIV_GO;
    issuing  = ((state_r == ST_SEED) || (state_r == ST_ASSIGN) || (state_r == ST_ACCUM))
               && (iss_r != total_c);
    case (state_r)
      ST_SEED:   pass_op = OP_SEED;
      ST_ASSIGN: pass_op = OP_ASSIGN;
      default:   pass_op = OP_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pos_r       <= '0;
      iss_r       <= '0;
      dim_r       <= '0;
      pt_r        <= '0;
      dr_r        <= '0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
      em_done_r   <= 1'b0;
      em_cl_r     <= '0;
      em_dim_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // load position: advance per stored word, drop words past the store
      if (in_acc) begin
        pos_r <= (pos_r == TW'(DEPTH)) ? pos_r : pos_r + 1'b1;
      end else if (state_r == ST_EMIT) begin
        pos_r <= '0;
      end

      // address walk; restart at every change of state
      if (state_r != state_nxt) begin
        iss_r <= '0;
        dim_r <= '0;
        pt_r  <= '0;
        dr_r  <= '0;
      end else if (issuing) begin
        iss_r <= iss_r + 1'b1;
        dim_r <= last_dim ? '0 : dim_r + 1'b1;
        pt_r  <= last_dim ? pt_r + 1'b1 : pt_r;
      end else if (dr_r != DRW'(DRAIN)) begin
        dr_r <= dr_r + 1'b1;
      end

      if (state_r == ST_SEED) begin
        rounds_r <= '0;
      end else if ((state_r == ST_DIVIDE) && !any_busy) begin
        rounds_r <= rounds_r + 1'b1;
      end

      // result register: load the next centre word while the current one drains
      if (state_r != ST_EMIT) begin
        em_done_r <= 1'b0;
        em_cl_r   <= '0;
        em_dim_r  <= '0;
      end else if (em_load) begin
        em_done_r <= em_last;
        if ((4'(em_dim_r) + 4'd1) == d_r) begin
          em_dim_r <= '0;
          em_cl_r  <= em_cl_r + 1'b1;
        end else begin
          em_dim_r <= em_dim_r + 1'b1;
        end
      end

      if (em_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and run registers
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      d_r  <= d_c;
      k_r  <= k_c;
      nd_r <= TW'(n_c) * TW'(d_c);
      kd_r <= TW'(k_c) * TW'(d_c);
    end

    c1_r.vld   <= rst_n && issuing;
    c1_r.op    <= pass_op;
    c1_r.first <= dim_r == '0;
    c1_r.last  <= last_dim;
    c1_r.dim   <= dim_r;
    c1_r.pt    <= PT_W'(pt_r);
    c1_r.tag   <= '0;
    c1_r.coord <= '0;

    if ((state_r != ST_ASSIGN) && (state_nxt == ST_ASSIGN)) begin
      sse_r <= '0;
    end else if (bst_w[MAX_CLUSTERS].vld) begin
      sse_r <= sse_r + EW'(bst_w[MAX_CLUSTERS].err);
    end

    if (state_r == ST_CHECK) begin
      prev_r <= sse_r;
    end

    if (em_load) begin
      out_data_r.center_value <= cen_w[em_cl_r];
      out_data_r.last_center  <= em_last;
    end
  end

  // point and membership memories, registered reads
  always_ff @(posedge clk) begin
    if (in_acc && (pos_r != TW'(DEPTH))) begin
      point_mem[pos_r[AW-1:0]] <= in_data.coord_value;
    end
    pm_q_r <= point_mem[iss_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bst_w[MAX_CLUSTERS].vld && (state_r == ST_ASSIGN)) begin
      member_mem[bst_w[MAX_CLUSTERS].pt[PW-1:0]] <= bst_w[MAX_CLUSTERS].idx;
    end
    mm_q_r <= member_mem[pt_r];
  end

  // head of the row: seeding steers each coordinate to the cell of its point
  always_comb begin
    elem0       = c1_r;
    elem0.coord = pm_q_r;
    elem0.tag   = (c1_r.op == OP_SEED) ? c1_r.pt[CL_W-1:0] : mm_q_r;
  end

  assign elem_w[0] = elem0;
  assign bst_w[0]  = '0;

  // ---- row of centre cells ----
  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kmc_cell #(
      .IDX        (g),
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .elem_i     (elem_w[g]),
      .elem_o     (elem_w[g+1]),
      .bst_i      (bst_w[g]),
      .bst_o      (bst_w[g+1]),
      .k_i        (k_r),
      .d_i        (d_r),
      .clr_i      (clr),
      .div_go_i   (div_go),
      .div_busy_o (busy_w[g]),
      .rd_dim_i   (em_dim_r),
      .center_o   (cen_w[g])
    );
  end

  // ---- checks ----
  a_out_in_emit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_EMIT))
    else $error("result word outside emission");

  a_decision_in_assign : assert property (@(posedge clk) disable iff (!rst_n)
    bst_w[MAX_CLUSTERS].vld |-> (state_r == ST_ASSIGN))
    else $error("nearest-centre decision outside assignment pass");

  a_row_drained : assert property (@(posedge clk) disable iff (!rst_n)
    elem_w[MAX_CLUSTERS].vld |-> ((state_r == ST_SEED) || (state_r == ST_ASSIGN)
                                  || (state_r == ST_ACCUM)))
    else $error("coordinate left in the row after a pass");

  a_div_window : assert property (@(posedge clk) disable iff (!rst_n)
    any_busy |-> (state_r == ST_DIVIDE))
    else $error("divider busy outside divide phase");

endmodule

`default_nettype wire
